>>> rtl/fqg_pkg.sv
package fqg_pkg;

	localparam int MaxQuadPoints = 16;
	localparam int MaxBasis = 16;
	localparam int QuadW = $clog2(MaxQuadPoints);
	localparam int BasisW = $clog2(MaxBasis);
	localparam int CountW = $clog2(MaxBasis + 1);
	localparam int AccW = 70;
	localparam int NumAcc = 6;
	localparam int AccIdxW = 3;

	localparam logic [1:0] OP_LOAD_BASIS = 2'd0;
	localparam logic [1:0] OP_LOAD_DERIV = 2'd1;
	localparam logic [1:0] OP_LOAD_COORD = 2'd2;
	localparam logic [1:0] OP_COMPUTE = 2'd3;

	localparam logic [2:0] KIND_POINT = 3'd0;
	localparam logic [2:0] KIND_JROW0 = 3'd1;
	localparam logic [2:0] KIND_JROW1 = 3'd2;
	localparam logic [2:0] KIND_IROW0 = 3'd3;
	localparam logic [2:0] KIND_IROW1 = 3'd4;
	localparam logic [2:0] KIND_DET = 3'd5;
	localparam logic [2:0] KIND_GRAD = 3'd6;

	localparam logic REG_NUM_BASIS = 1'b0;
	localparam logic REG_MIN_DET = 1'b1;

	typedef struct packed {
		logic [1:0] opcode;
		logic [3:0] quad_index;
		logic [3:0] basis_index;
		logic axis;
		logic signed [31:0] load_value;
	} cmd_t;

	typedef struct packed {
		logic [3:0] out_quad_index;
		logic [3:0] out_basis_index;
		logic [2:0] kind;
		logic signed [31:0] value_a;
		logic signed [31:0] value_b;
		logic bad_det;
		logic last;
	} res_t;

	typedef struct packed {
		logic clear;
		logic issue;
		logic sub;
		logic [AccIdxW-1:0] dest;
	} mac_ctl_t;

	typedef enum logic [4:0] {
		S_IDLE, S_RD0, S_RD1, S_RD2, S_MAC, S_FLUSH, S_JL,
		S_DET0, S_DET1, S_DFL, S_DETL, S_DIV, S_DIVW, S_HDR,
		S_GRD0, S_GRD1, S_GRD2, S_GMAC, S_GFL, S_GOUT
	} state_t;

	function automatic logic signed [31:0] round_sat(input logic signed [AccW-1:0] a);
		logic signed [AccW-1:0] t;
		t = a + AccW'(32768);
		t = t >>> 16;
		if (t > 70'sd2147483647)
			return 32'sh7fffffff;
		else if (t < -70'sd2147483648)
			return 32'sh80000000;
		else
			return t[31:0];
	endfunction

endpackage

>>> rtl/fem_quadrature_geometry_2d_top.sv
// Channel   | Ports                              | Transfer
// command   | start, busy, cmd                   | start high while busy is low
// result    | res_valid, res                     | res_valid high for one cycle
// config    | psel, penable, pwrite, paddr, ...  | access phase, pready always high
// A load leaves busy low. A compute item keeps busy high through the shared
// multiply-accumulate unit (one product a cycle, table reads in between) and the
// four 48-step divisions by the determinant.
// Reset idles the sequencer and sets num_basis to 3, min_det to 0; the tables hold nothing
// until loaded. Results cannot be stalled; busy falls as the last result of a run appears.
module fem_quadrature_geometry_2d_top
	import fqg_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input cmd_t cmd,
	output logic res_valid,
	output res_t res,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	state_t state_q, state_nx;
	logic [4:0] num_basis_q;
	logic signed [31:0] min_det_q;
	logic [CountW-1:0] n_q;
	logic [QuadW-1:0] q_q;
	logic [BasisW-1:0] i_q;
	logic [2:0] k_q;
	logic [1:0] d_q;
	logic signed [31:0] nv_q, dp_q, dq_q, xc_q, yc_q;
	logic signed [31:0] px_q, py_q, j00_q, j01_q, j10_q, j11_q, det_q;
	logic signed [31:0] inv_q [4];
	logic bad_q;
	logic accept;
	logic last_basis;
	logic rd_axis;
	logic signed [31:0] basis_rd, deriv_rd, coord_rd;
	mac_ctl_t mac_ctl;
	logic signed [31:0] op_a, op_b;
	logic signed [31:0] rnd [NumAcc];
	logic div_start, div_done;
	logic signed [32:0] div_cof;
	logic signed [31:0] div_quo;
	res_t hdr;

	assign accept = start && state_q == S_IDLE;
	assign busy = state_q != S_IDLE;
	assign last_basis = CountW'(i_q) + CountW'(1) == n_q;
	assign pready = 1'b1;
	assign prdata = paddr[2] == REG_MIN_DET ? min_det_q : {27'd0, num_basis_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_basis_q <= 5'd3;
			min_det_q <= '0;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_NUM_BASIS)
				num_basis_q <= pwdata[4:0];
			else
				min_det_q <= pwdata;
		end
	end

	fqg_tables u_tables (
		.clk(clk),
		.we(accept && cmd.opcode != OP_COMPUTE),
		.wcmd(cmd),
		.rd_quad(q_q),
		.rd_basis(i_q),
		.rd_axis(rd_axis),
		.basis_rd(basis_rd),
		.deriv_rd(deriv_rd),
		.coord_rd(coord_rd)
	);

	fqg_mac u_mac (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(mac_ctl),
		.op_a(op_a),
		.op_b(op_b),
		.rnd(rnd)
	);

	always_comb begin
		case (d_q)
			2'd0: div_cof = 33'(j11_q);
			2'd1: div_cof = -33'(j01_q);
			2'd2: div_cof = -33'(j10_q);
			default: div_cof = 33'(j00_q);
		endcase
	end

	fqg_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.cof(div_cof),
		.den(det_q),
		.done(div_done),
		.quo(div_quo)
	);

	always_comb begin
		hdr.out_quad_index = q_q;
		hdr.out_basis_index = '0;
		hdr.bad_det = bad_q;
		hdr.last = k_q == 3'd5 && n_q == '0;
		case (k_q)
			3'd0: begin
				hdr.kind = KIND_POINT;
				hdr.value_a = px_q;
				hdr.value_b = py_q;
			end
			3'd1: begin
				hdr.kind = KIND_JROW0;
				hdr.value_a = j00_q;
				hdr.value_b = j01_q;
			end
			3'd2: begin
				hdr.kind = KIND_JROW1;
				hdr.value_a = j10_q;
				hdr.value_b = j11_q;
			end
			3'd3: begin
				hdr.kind = KIND_DET;
				hdr.value_a = det_q;
				hdr.value_b = '0;
			end
			3'd4: begin
				hdr.kind = KIND_IROW0;
				hdr.value_a = inv_q[0];
				hdr.value_b = inv_q[1];
			end
			default: begin
				hdr.kind = KIND_IROW1;
				hdr.value_a = inv_q[2];
				hdr.value_b = inv_q[3];
			end
		endcase
	end

	always_comb begin
		state_nx = state_q;
		mac_ctl = '0;
		op_a = nv_q;
		op_b = xc_q;
		rd_axis = 1'b0;
		div_start = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (start && cmd.opcode == OP_COMPUTE) begin
					mac_ctl.clear = 1'b1;
					state_nx = (num_basis_q == '0) ? S_FLUSH : S_RD0;
				end
			end
			S_RD0: state_nx = S_RD1;
			S_RD1: begin
				rd_axis = 1'b1;
				state_nx = S_RD2;
			end
			S_RD2: state_nx = S_MAC;
			S_MAC: begin
				mac_ctl.issue = 1'b1;
				mac_ctl.dest = k_q;
				case (k_q)
					3'd0: begin op_a = nv_q; op_b = xc_q; end
					3'd1: begin op_a = nv_q; op_b = yc_q; end
					3'd2: begin op_a = dp_q; op_b = xc_q; end
					3'd3: begin op_a = dq_q; op_b = xc_q; end
					3'd4: begin op_a = dp_q; op_b = yc_q; end
					default: begin op_a = dq_q; op_b = yc_q; end
				endcase
				if (k_q == 3'd5)
					state_nx = last_basis ? S_FLUSH : S_RD0;
			end
			S_FLUSH: state_nx = S_JL;
			S_JL: begin
				mac_ctl.clear = 1'b1;
				state_nx = S_DET0;
			end
			S_DET0: begin
				mac_ctl.issue = 1'b1;
				op_a = j00_q;
				op_b = j11_q;
				state_nx = S_DET1;
			end
			S_DET1: begin
				mac_ctl.issue = 1'b1;
				mac_ctl.sub = 1'b1;
				op_a = j01_q;
				op_b = j10_q;
				state_nx = S_DFL;
			end
			S_DFL: state_nx = S_DETL;
			S_DETL: begin
				mac_ctl.clear = 1'b1;
				state_nx = S_DIV;
			end
			S_DIV: begin
				div_start = 1'b1;
				state_nx = S_DIVW;
			end
			S_DIVW: begin
				if (div_done)
					state_nx = (d_q == 2'd3) ? S_HDR : S_DIV;
			end
			S_HDR: begin
				if (k_q == 3'd5)
					state_nx = (n_q == '0) ? S_IDLE : S_GRD0;
			end
			S_GRD0: state_nx = S_GRD1;
			S_GRD1: begin
				rd_axis = 1'b1;
				state_nx = S_GRD2;
			end
			S_GRD2: state_nx = S_GMAC;
			S_GMAC: begin
				mac_ctl.issue = 1'b1;
				case (k_q)
					3'd0: begin op_a = dp_q; op_b = inv_q[0]; end
					3'd1: begin op_a = dq_q; op_b = inv_q[2]; end
					3'd2: begin op_a = dp_q; op_b = inv_q[1]; mac_ctl.dest = 3'd1; end
					default: begin op_a = dq_q; op_b = inv_q[3]; mac_ctl.dest = 3'd1; end
				endcase
				if (k_q == 3'd3)
					state_nx = S_GFL;
			end
			S_GFL: state_nx = S_GOUT;
			S_GOUT: begin
				mac_ctl.clear = 1'b1;
				state_nx = last_basis ? S_IDLE : S_GRD0;
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			res_valid <= 1'b0;
		end else begin
			state_q <= state_nx;
			res_valid <= state_q == S_HDR || state_q == S_GOUT;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				q_q <= cmd.quad_index;
				i_q <= '0;
				k_q <= '0;
				n_q <= (num_basis_q > 5'(MaxBasis)) ? CountW'(MaxBasis) : CountW'(num_basis_q);
			end
			S_RD1: begin
				nv_q <= basis_rd;
				dp_q <= deriv_rd;
				xc_q <= coord_rd;
			end
			S_RD2: begin
				dq_q <= deriv_rd;
				yc_q <= coord_rd;
				k_q <= '0;
			end
			S_MAC: begin
				k_q <= k_q + 3'd1;
				if (k_q == 3'd5)
					i_q <= i_q + BasisW'(1);
			end
			S_JL: begin
				px_q <= rnd[0];
				py_q <= rnd[1];
				j00_q <= rnd[2];
				j01_q <= rnd[3];
				j10_q <= rnd[4];
				j11_q <= rnd[5];
			end
			S_DETL: begin
				det_q <= rnd[0];
				bad_q <= rnd[0] < min_det_q;
				d_q <= '0;
			end
			S_DIVW: begin
				if (div_done) begin
					inv_q[d_q] <= div_quo;
					d_q <= d_q + 2'd1;
					k_q <= '0;
				end
			end
			S_HDR: begin
				res <= hdr;
				k_q <= k_q + 3'd1;
				i_q <= '0;
			end
			S_GRD1: dp_q <= deriv_rd;
			S_GRD2: begin
				dq_q <= deriv_rd;
				k_q <= '0;
			end
			S_GMAC: k_q <= k_q + 3'd1;
			S_GOUT: begin
				res.out_quad_index <= q_q;
				res.out_basis_index <= i_q;
				res.kind <= KIND_GRAD;
				res.value_a <= rnd[0];
				res.value_b <= rnd[1];
				res.bad_det <= bad_q;
				res.last <= last_basis;
				i_q <= i_q + BasisW'(1);
			end
			default: ;
		endcase
	end

endmodule

>>> rtl/fqg_tables.sv
module fqg_tables
	import fqg_pkg::*;
(
	input logic clk,
	input logic we,
	input cmd_t wcmd,
	input logic [QuadW-1:0] rd_quad,
	input logic [BasisW-1:0] rd_basis,
	input logic rd_axis,
	output logic signed [31:0] basis_rd,
	output logic signed [31:0] deriv_rd,
	output logic signed [31:0] coord_rd
);

	logic signed [31:0] basis_mem [MaxQuadPoints*MaxBasis];
	logic signed [31:0] deriv_mem [MaxQuadPoints*MaxBasis*2];
	logic signed [31:0] coord_mem [MaxBasis*2];

	always_ff @(posedge clk) begin
		if (we && wcmd.opcode == OP_LOAD_BASIS)
			basis_mem[{wcmd.quad_index, wcmd.basis_index}] <= wcmd.load_value;
		if (we && wcmd.opcode == OP_LOAD_DERIV)
			deriv_mem[{wcmd.quad_index, wcmd.basis_index, wcmd.axis}] <= wcmd.load_value;
		if (we && wcmd.opcode == OP_LOAD_COORD)
			coord_mem[{wcmd.basis_index, wcmd.axis}] <= wcmd.load_value;
	end

	always_ff @(posedge clk) begin
		basis_rd <= basis_mem[{rd_quad, rd_basis}];
		deriv_rd <= deriv_mem[{rd_quad, rd_basis, rd_axis}];
		coord_rd <= coord_mem[{rd_basis, rd_axis}];
	end

endmodule

>>> rtl/fqg_mac.sv
module fqg_mac
	import fqg_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input mac_ctl_t ctl,
	input logic signed [31:0] op_a,
	input logic signed [31:0] op_b,
	output logic signed [31:0] rnd [NumAcc]
);

	logic signed [63:0] prod_s1;
	logic pv_s1;
	logic sub_s1;
	logic [AccIdxW-1:0] dest_s1;
	logic signed [AccW-1:0] acc_q [NumAcc];
	logic signed [AccW-1:0] term;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pv_s1 <= 1'b0;
		else
			pv_s1 <= ctl.issue;
	end

	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
		sub_s1 <= ctl.sub;
		dest_s1 <= ctl.dest;
	end

	assign term = sub_s1 ? -AccW'(prod_s1) : AccW'(prod_s1);

	always_ff @(posedge clk) begin
		for (int k = 0; k < NumAcc; k++) begin
			if (ctl.clear)
				acc_q[k] <= '0;
			else if (pv_s1 && dest_s1 == AccIdxW'(k))
				acc_q[k] <= acc_q[k] + term;
		end
	end

	always_comb begin
		for (int k = 0; k < NumAcc; k++)
			rnd[k] = round_sat(acc_q[k]);
	end

endmodule

>>> rtl/fqg_div.sv
module fqg_div
	import fqg_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [32:0] cof,
	input logic signed [31:0] den,
	output logic done,
	output logic signed [31:0] quo
);

	logic [47:0] num_q;
	logic [47:0] quo_q;
	logic [31:0] den_q;
	logic [32:0] rem_q;
	logic [5:0] cnt_q;
	logic run_q;
	logic done_q;
	logic neg_q;
	logic zero_q;
	logic [32:0] cof_mag;
	logic [32:0] trial;
	logic fits;

	assign cof_mag = cof[32] ? 33'(-cof) : 33'(cof);
	assign trial = {rem_q[31:0], num_q[47]};
	assign fits = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= 6'd47;
			end else if (run_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == '0) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= {cof_mag[31:0], 16'd0};
			den_q <= den[31] ? 32'(-den) : 32'(den);
			rem_q <= '0;
			quo_q <= '0;
			neg_q <= cof[32] ^ den[31];
			zero_q <= den == '0;
		end else if (run_q) begin
			rem_q <= fits ? trial - {1'b0, den_q} : trial;
			quo_q <= {quo_q[46:0], fits};
			num_q <= {num_q[46:0], 1'b0};
		end
	end

	// Magnitudes are divided, so the quotient truncates toward zero.
	always_comb begin
		if (zero_q)
			quo = '0;
		else if (!neg_q)
			quo = (quo_q > 48'h7fffffff) ? 32'sh7fffffff : quo_q[31:0];
		else
			quo = (quo_q > 48'h80000000) ? 32'sh80000000 : -quo_q[31:0];
	end

	assign done = done_q;

endmodule

>>> rtl/fqg_chk.sv
module fqg_chk
	import fqg_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic res_valid,
	input res_t res
);

	// The final transfer of a run is never followed directly by another result.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.last |=> !res_valid)
		else $error("result follows the last result of a run");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.last |-> busy)
		else $error("block idle while a run is still open");

	assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> !res_valid)
		else $error("result right after a command transfer");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && $past(res_valid) |-> res.out_quad_index == $past(res.out_quad_index))
		else $error("quadrature index changed within a run");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.kind == KIND_DET |-> res.value_b == '0)
		else $error("determinant result with nonzero second value");

endmodule

bind fem_quadrature_geometry_2d_top fqg_chk u_chk (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.res_valid(res_valid),
	.res(res)
);

>>> tb/fem_quadrature_geometry_2d_top_tb.sv
`timescale 1ns / 100ps

module fem_quadrature_geometry_2d_top_tb;
	import fqg_pkg::*;

	localparam int CycleLimit = 600000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	cmd_t cmd = '0;
	logic res_valid;
	res_t res;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	fem_quadrature_geometry_2d_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.res_valid(res_valid), .res(res), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.pready(pready)
	);

	always #1 clk = ~clk;

	cmd_t pending_cmds[$];
	res_t expected_res[$];
	int mismatches = 0;
	int cycles = 0;
	int idle_pct = 12;
	logic took = 1'b0;
	logic driving = 1'b0;

	// Mirror of the block state, updated as each transfer is accepted.
	logic signed [31:0] basis_val[16][16];
	logic signed [31:0] ref_deriv[16][16][2];
	logic signed [31:0] node_xy[16][2];
	int num_basis_cfg = 3;
	logic signed [31:0] min_det_cfg = 0;

	// Entries already queued for loading, so computes never read unwritten entries.
	bit basis_set[16][16];
	bit deriv_set[16][16][2];
	bit node_set[16][2];

	function automatic logic signed [31:0] sat_q(input logic signed [79:0] a);
		if (a > 80'sd2147483647)
			return 32'sh7fffffff;
		if (a < -80'sd2147483648)
			return 32'sh80000000;
		return a[31:0];
	endfunction

	function automatic logic signed [31:0] round_q(input logic signed [79:0] a);
		return sat_q((a + 80'sd32768) >>> 16);
	endfunction

	function automatic logic signed [31:0] div_by_det(input longint cof,
			input logic signed [31:0] det);
		longint quo;
		if (det == 0)
			return 0;
		quo = (cof * 65536) / longint'(det);
		return sat_q(80'(quo));
	endfunction

	function automatic res_t make_res(input logic [3:0] q, input logic [3:0] b,
			input logic [2:0] k, input logic signed [31:0] va, input logic signed [31:0] vb,
			input logic bad, input logic fin);
		res_t r;
		r.out_quad_index = q;
		r.out_basis_index = b;
		r.kind = k;
		r.value_a = va;
		r.value_b = vb;
		r.bad_det = bad;
		r.last = fin;
		return r;
	endfunction

	task automatic predict_geometry(input logic [3:0] q);
		int n;
		logic signed [79:0] sx, sy, s00, s01, s10, s11, sd, gx, gy;
		logic signed [31:0] j00, j01, j10, j11, det, i00, i01, i10, i11;
		logic bad;
		n = num_basis_cfg > MaxBasis ? MaxBasis : num_basis_cfg;
		sx = 0; sy = 0; s00 = 0; s01 = 0; s10 = 0; s11 = 0; sd = 0;
		for (int i = 0; i < n; i++) begin
			sx += longint'(basis_val[q][i]) * longint'(node_xy[i][0]);
			sy += longint'(basis_val[q][i]) * longint'(node_xy[i][1]);
			s00 += longint'(ref_deriv[q][i][0]) * longint'(node_xy[i][0]);
			s01 += longint'(ref_deriv[q][i][1]) * longint'(node_xy[i][0]);
			s10 += longint'(ref_deriv[q][i][0]) * longint'(node_xy[i][1]);
			s11 += longint'(ref_deriv[q][i][1]) * longint'(node_xy[i][1]);
		end
		j00 = round_q(s00); j01 = round_q(s01);
		j10 = round_q(s10); j11 = round_q(s11);
		sd += longint'(j00) * longint'(j11);
		sd -= longint'(j01) * longint'(j10);
		det = round_q(sd);
		bad = det < min_det_cfg;
		i00 = div_by_det(longint'(j11), det);
		i01 = div_by_det(-longint'(j01), det);
		i10 = div_by_det(-longint'(j10), det);
		i11 = div_by_det(longint'(j00), det);
		expected_res.push_back(make_res(q, 0, KIND_POINT, round_q(sx), round_q(sy), bad, 0));
		expected_res.push_back(make_res(q, 0, KIND_JROW0, j00, j01, bad, 0));
		expected_res.push_back(make_res(q, 0, KIND_JROW1, j10, j11, bad, 0));
		expected_res.push_back(make_res(q, 0, KIND_DET, det, 0, bad, 0));
		expected_res.push_back(make_res(q, 0, KIND_IROW0, i00, i01, bad, 0));
		expected_res.push_back(make_res(q, 0, KIND_IROW1, i10, i11, bad, n == 0));
		for (int i = 0; i < n; i++) begin
			gx = 0; gy = 0;
			gx += longint'(ref_deriv[q][i][0]) * longint'(i00);
			gx += longint'(ref_deriv[q][i][1]) * longint'(i10);
			gy += longint'(ref_deriv[q][i][0]) * longint'(i01);
			gy += longint'(ref_deriv[q][i][1]) * longint'(i11);
			expected_res.push_back(make_res(q, 4'(i), KIND_GRAD, round_q(gx), round_q(gy),
				bad, i + 1 == n));
		end
	endtask

	// Accept transfers, update the mirror and check results.
	always @(posedge clk) begin
		res_t e;
		if (arst_n) begin
			cycles <= cycles + 1;
			took <= start && !busy;
			if (start && !busy) begin
				case (cmd.opcode)
					OP_LOAD_BASIS: basis_val[cmd.quad_index][cmd.basis_index] = cmd.load_value;
					OP_LOAD_DERIV:
						ref_deriv[cmd.quad_index][cmd.basis_index][cmd.axis] = cmd.load_value;
					OP_LOAD_COORD: node_xy[cmd.basis_index][cmd.axis] = cmd.load_value;
					default: predict_geometry(cmd.quad_index);
				endcase
			end
			if (res_valid) begin
				if (expected_res.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: %p", res);
				end else begin
					e = expected_res.pop_front();
					if (res.out_quad_index !== e.out_quad_index ||
						res.out_basis_index !== e.out_basis_index || res.kind !== e.kind ||
						res.value_a !== e.value_a || res.value_b !== e.value_b ||
						res.bad_det !== e.bad_det || res.last !== e.last) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %p, got %p", e, res);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (cycles > CycleLimit) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Drive commands at the falling edge; a command is held until its transfer.
	always @(negedge clk) begin
		if (driving && !(start && !took)) begin
			if (pending_cmds.size() > 0 && $urandom_range(99) >= idle_pct) begin
				cmd <= pending_cmds.pop_front();
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	function automatic logic signed [31:0] pick_value(input int span);
		case ($urandom_range(9))
			0: return 32'sh80000000;
			1: return 32'sh7fffffff;
			2: return $urandom;
			default: return $signed($urandom_range(0, 2 * span)) - span;
		endcase
	endfunction

	task automatic queue_load(input logic [1:0] op, input int q, input int b, input int ax,
			input logic signed [31:0] v);
		cmd_t c;
		c.opcode = op;
		c.quad_index = 4'(q);
		c.basis_index = 4'(b);
		c.axis = ax[0];
		c.load_value = v;
		pending_cmds.push_back(c);
		case (op)
			OP_LOAD_BASIS: basis_set[q][b] = 1;
			OP_LOAD_DERIV: deriv_set[q][b][ax] = 1;
			OP_LOAD_COORD: node_set[b][ax] = 1;
			default: ;
		endcase
	endtask

	// Load whatever the point still lacks, then ask for the geometry.
	task automatic queue_compute(input int q);
		int n;
		cmd_t c;
		n = num_basis_cfg > MaxBasis ? MaxBasis : num_basis_cfg;
		for (int i = 0; i < n; i++) begin
			if (!basis_set[q][i])
				queue_load(OP_LOAD_BASIS, q, i, 0, pick_value(1 << 16));
			for (int a = 0; a < 2; a++) begin
				if (!deriv_set[q][i][a])
					queue_load(OP_LOAD_DERIV, q, i, a, pick_value(2 << 16));
				if (!node_set[i][a])
					queue_load(OP_LOAD_COORD, q, i, a, pick_value(8 << 16));
			end
		end
		c = '0;
		c.opcode = OP_COMPUTE;
		c.quad_index = 4'(q);
		c.basis_index = 4'($urandom);
		c.axis = 1'($urandom);
		c.load_value = $urandom;
		pending_cmds.push_back(c);
	endtask

	task automatic drain;
		wait (pending_cmds.size() == 0 && !start);
		wait (expected_res.size() == 0);
		wait (!busy);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input logic regsel, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {regsel, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (regsel == REG_NUM_BASIS)
			num_basis_cfg = int'(value[4:0]);
		else
			min_det_cfg = value;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Computes stay on two points so that full tables for sixteen basis functions
	// do not swamp the run with loads.
	task automatic random_phase(input int count);
		int q;
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(9) < 7) begin
				q = $urandom_range(1);
				repeat ($urandom_range(4))
					queue_load(2'($urandom_range(2)), q, $urandom_range(15),
						$urandom_range(1), pick_value(4 << 16));
				queue_compute(q);
			end else begin
				queue_load(2'($urandom_range(2)), $urandom_range(15), $urandom_range(15),
					$urandom_range(1), $urandom);
			end
		end
	endtask

	initial begin
		int nb_list[6];
		logic [31:0] det_list[6];
		nb_list = '{3, 1, 16, 0, 20, 2};
		det_list = '{32'h0, 32'h80000000, 32'h7fffffff, 32'h0, 32'h00010000, 32'hffff0000};
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		write_reg(REG_NUM_BASIS, 32'd3);
		write_reg(REG_MIN_DET, 32'd0);
		driving = 1'b1;

		// Degenerate cell: every node at the origin gives a zero determinant.
		for (int i = 0; i < 3; i++) begin
			queue_load(OP_LOAD_COORD, 0, i, 0, 0);
			queue_load(OP_LOAD_COORD, 0, i, 1, 0);
		end
		queue_compute(0);
		// Extreme basis and derivative values; the nodes are still at the origin, so the sums stay zero.
		for (int i = 0; i < 3; i++) begin
			queue_load(OP_LOAD_BASIS, 15, i, 0, 32'sh7fffffff);
			queue_load(OP_LOAD_DERIV, 15, i, 0, 32'sh80000000);
			queue_load(OP_LOAD_DERIV, 15, i, 1, 32'sh7fffffff);
		end
		queue_load(OP_LOAD_COORD, 0, 15, 1, 32'sh80000000);
		queue_compute(15);
		queue_compute(7);
		drain();

		for (int p = 0; p < 6; p++) begin
			write_reg(REG_NUM_BASIS, nb_list[p]);
			write_reg(REG_MIN_DET, det_list[p]);
			idle_pct = (p == 2) ? 0 : 12;
			random_phase(p == 2 ? 4 : 6);
			drain();
		end

		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
